>>> src/svpwm_pkg.sv
// Shared types and constants for the min-max injection SVPWM duty pipeline.
package svpwm_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam logic [14:0] LIMIT_DEFAULT = 15'd28378;
  localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  // Configuration register indexes
  localparam logic REG_MAX_MOD = 1'b0;
  localparam logic REG_AUTO_SCALE = 1'b1;

  // Item data carried alongside the magnitude and scale units
  typedef struct packed {
    logic signed [15:0] al;
    logic signed [15:0] be;
    logic [14:0]        lim;
    logic               over;
    logic               aut;
  } side_t;

endpackage

>>> src/svpwm_minmax_duty.sv
// Top level of the min-max injection SVPWM duty pipeline.
// Each item is an alpha/beta vector in signed Q1.15; each yields one result with
// three Q15 duties, the applied scale and the valid and saturated flags. The block
// is a 30-stage pipeline: 3 stages of limit check, 9 of square root, 10 of scale
// division and 8 of scaling, inverse Clarke, injection and clamping. It accepts one
// item per cycle unless the pipeline holds; the whole pipeline holds while a
// finished result waits on out_stall. Write configuration only while the pipeline
// is empty.
module svpwm_minmax_duty
  import svpwm_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [14:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] alpha_in,
  input  logic signed [DATA_WIDTH-1:0] beta_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  duty_phase_a,
  output logic [15:0]                  duty_phase_b,
  output logic [15:0]                  duty_phase_c,
  output logic [15:0]                  applied_scale,
  output logic                         result_valid,
  output logic                         saturated_flag
);

  logic        adv;
  logic [14:0] max_modulation;
  logic        auto_scale_enable;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_modulation    <= LIMIT_DEFAULT;
      auto_scale_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_MOD:    max_modulation    <= cfg_data;
        REG_AUTO_SCALE: auto_scale_enable <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  function automatic logic signed [15:0] sat16(input logic signed [32:0] x);
    if (x > 33'sd32767) begin
      return 16'sh7fff;
    end else if (x < -33'sd32768) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

  logic        v1, v2, v3;
  side_t       s1, s2, s3;
  logic [31:0] a2sq, b2sq, sq3;
  logic [29:0] l2sq;

  // Stage 1: saturate inputs, settle the effective limit
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (adv) begin
      s1.al   <= sat16(33'(alpha_in));
      s1.be   <= sat16(33'(beta_in));
      s1.lim  <= (max_modulation == 15'd0 || max_modulation > LIMIT_DEFAULT) ?
                 LIMIT_DEFAULT : max_modulation;
      s1.over <= 1'b0;
      s1.aut  <= auto_scale_enable;
      // Stage 2: squares
      s2   <= s1;
      a2sq <= 32'(s1.al * s1.al);
      b2sq <= 32'(s1.be * s1.be);
      l2sq <= s1.lim * s1.lim;
      // Stage 3: magnitude squared against the limit
      sq3 <= a2sq + b2sq;
      s3  <= '{al: s2.al, be: s2.be, lim: s2.lim,
               over: (a2sq + b2sq) > {2'b00, l2sq}, aut: s2.aut};
    end
  end

  logic        v_sq;
  logic [15:0] mag;
  side_t       s_sq;

  svpwm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (v3),
    .x        (sq3),
    .in_side  (s3),
    .out_vld  (v_sq),
    .m        (mag),
    .out_side (s_sq)
  );

  logic        v_dv;
  logic [16:0] quo;
  side_t       s_dv;

  svpwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (v_sq),
    .m        (mag),
    .in_side  (s_sq),
    .out_vld  (v_dv),
    .q        (quo),
    .out_side (s_dv)
  );

  svpwm_duty u_duty (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (v_dv),
    .q       (quo),
    .in_side (s_dv),
    .out_vld (out_valid),
    .da      (duty_phase_a),
    .db      (duty_phase_b),
    .dc      (duty_phase_c),
    .scale   (applied_scale),
    .ok      (result_valid),
    .sat     (saturated_flag)
  );

endmodule

>>> src/svpwm_sqrt.sv
// Pipelined rounded integer square root, two root bits per stage.
module svpwm_sqrt
  import svpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  logic [31:0] x,
  input  side_t       in_side,
  output logic        out_vld,
  output logic [15:0] m,
  output side_t       out_side
);

  localparam int NSTG = 8;

  logic        vld_q  [NSTG];
  logic [15:0] root_q [NSTG];
  logic [19:0] rem_q  [NSTG];
  logic [31:0] x_q    [NSTG];
  side_t       side_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic        src_vld;
    logic [15:0] src_root;
    logic [19:0] src_rem;
    logic [31:0] src_x;
    side_t       src_side;
    logic [15:0] root_next;
    logic [19:0] rem_next;

    if (s == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_root = '0;
      assign src_rem  = '0;
      assign src_x    = x;
      assign src_side = in_side;
    end else begin : g_rest
      assign src_vld  = vld_q[s-1];
      assign src_root = root_q[s-1];
      assign src_rem  = rem_q[s-1];
      assign src_x    = x_q[s-1];
      assign src_side = side_q[s-1];
    end

    // Bring down two radicand bits per step, try the next root bit
    always_comb begin
      logic [19:0] trial;
      root_next = src_root;
      rem_next  = src_rem;
      for (int t = 0; t < 2; t++) begin
        rem_next = {rem_next[17:0], src_x[2*(15-2*s-t)+1], src_x[2*(15-2*s-t)]};
        trial = {2'b00, root_next, 2'b01};
        if (rem_next >= trial) begin
          rem_next  = rem_next - trial;
          root_next = {root_next[14:0], 1'b1};
        end else begin
          root_next = {root_next[14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (adv) begin
        vld_q[s] <= src_vld;
      end
      if (adv) begin
        root_q[s] <= root_next;
        rem_q[s]  <= rem_next;
        x_q[s]    <= src_x;
        side_q[s] <= src_side;
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= vld_q[NSTG-1];
    end
    if (adv) begin
      if (rem_q[NSTG-1] > {4'b0000, root_q[NSTG-1]}) begin
        m <= 16'(root_q[NSTG-1] + 16'd1);
      end else begin
        m <= root_q[NSTG-1];
      end
      out_side <= side_q[NSTG-1];
    end
  end

endmodule

>>> src/svpwm_div.sv
// Pipelined restoring divider for the scale, round(lim*32768/m), up to two bits per stage.
module svpwm_div
  import svpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  logic [15:0] m,
  input  side_t       in_side,
  output logic        out_vld,
  output logic [16:0] q,
  output side_t       out_side
);

  localparam int QBITS = 17;
  localparam int NSTG  = (QBITS + 1) / 2;

  // Prepare numerator lim*65536+m and divisor 2m
  logic        p_vld;
  logic [16:0] p_low;
  logic [17:0] p_rem;
  logic [16:0] p_den;
  side_t       p_side;

  always_ff @(posedge clk) begin
    logic [31:0] num;
    num = {1'b0, in_side.lim, 16'h0000} + {16'h0000, m};
    if (rst) begin
      p_vld <= 1'b0;
    end else if (adv) begin
      p_vld <= in_vld;
    end
    if (adv) begin
      p_low  <= num[16:0];
      p_rem  <= {3'b000, num[31:17]};
      p_den  <= {m, 1'b0};
      p_side <= in_side;
    end
  end

  logic        vld_q  [NSTG];
  logic [16:0] low_q  [NSTG];
  logic [17:0] rem_q  [NSTG];
  logic [16:0] den_q  [NSTG];
  logic [16:0] quo_q  [NSTG];
  side_t       side_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic        src_vld;
    logic [16:0] src_low;
    logic [17:0] src_rem;
    logic [16:0] src_den;
    logic [16:0] src_quo;
    side_t       src_side;
    logic [17:0] rem_next;
    logic [16:0] quo_next;

    if (s == 0) begin : g_first
      assign src_vld  = p_vld;
      assign src_low  = p_low;
      assign src_rem  = p_rem;
      assign src_den  = p_den;
      assign src_quo  = '0;
      assign src_side = p_side;
    end else begin : g_rest
      assign src_vld  = vld_q[s-1];
      assign src_low  = low_q[s-1];
      assign src_rem  = rem_q[s-1];
      assign src_den  = den_q[s-1];
      assign src_quo  = quo_q[s-1];
      assign src_side = side_q[s-1];
    end

    // Shift in the next numerator bit and subtract where it fits
    always_comb begin
      rem_next = src_rem;
      quo_next = src_quo;
      for (int t = 0; t < 2; t++) begin
        if (2*s + t < QBITS) begin
          rem_next = {rem_next[16:0], src_low[QBITS-1-(2*s+t)]};
          if (rem_next >= {1'b0, src_den}) begin
            rem_next = rem_next - {1'b0, src_den};
            quo_next = {quo_next[15:0], 1'b1};
          end else begin
            quo_next = {quo_next[15:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (adv) begin
        vld_q[s] <= src_vld;
      end
      if (adv) begin
        low_q[s]  <= src_low;
        rem_q[s]  <= rem_next;
        den_q[s]  <= src_den;
        quo_q[s]  <= quo_next;
        side_q[s] <= src_side;
      end
    end
  end

  assign out_vld  = vld_q[NSTG-1];
  assign q        = quo_q[NSTG-1];
  assign out_side = side_q[NSTG-1];

endmodule

>>> src/svpwm_duty.sv
// Vector scaling, inverse Clarke, min-max injection and duty clamping stages.
module svpwm_duty
  import svpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  logic [16:0] q,
  input  side_t       in_side,
  output logic        out_vld,
  output logic [15:0] da,
  output logic [15:0] db,
  output logic [15:0] dc,
  output logic [15:0] scale,
  output logic        ok,
  output logic        sat
);

  typedef struct packed {
    logic [15:0] sc;
    logic        ok;
    logic        sat;
  } tag_t;

  logic [6:0] v;
  tag_t       tg [7];

  logic signed [15:0] al0, be0;
  logic signed [32:0] al1, be1;
  logic signed [16:0] al2, be2;
  logic signed [16:0] al3;
  logic signed [34:0] kb3;
  logic signed [35:0] pa4, pb4, pc4;
  logic signed [35:0] pa5, pb5, pc5, mx5, mn5;
  logic signed [37:0] ta6, tb6, tc6;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v       <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      v       <= {v[5:0], in_vld};
      out_vld <= v[6];
    end
  end

  function automatic logic signed [16:0] round_q15(input logic signed [32:0] p);
    logic signed [33:0] pe;
    logic signed [33:0] r;
    pe = 34'(p);
    if (!pe[33]) begin
      r = (pe + 34'sd16384) >>> 15;
    end else begin
      r = -((-pe + 34'sd16384) >>> 15);
    end
    return r[16:0];
  endfunction

  function automatic logic [15:0] to_duty(input logic signed [37:0] t);
    logic signed [37:0] r;
    if (t <= 38'sd0) begin
      return 16'd0;
    end
    r = (t + 38'sd65536) >>> 17;
    if (r > 38'sd32768) begin
      return ONE_Q15;
    end
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      // Pick the applied scale and the flags
      if (in_side.over && in_side.aut) begin
        tg[0].sc <= (q > {1'b0, ONE_Q15}) ? ONE_Q15 : q[15:0];
      end else begin
        tg[0].sc <= ONE_Q15;
      end
      tg[0].ok  <= !(in_side.over && !in_side.aut);
      tg[0].sat <= in_side.over;
      al0 <= in_side.al;
      be0 <= in_side.be;
      for (int i = 1; i < 7; i++) begin
        tg[i] <= tg[i-1];
      end
      // Scale the vector
      al1 <= al0 * $signed({1'b0, tg[0].sc});
      be1 <= be0 * $signed({1'b0, tg[0].sc});
      al2 <= round_q15(al1);
      be2 <= round_q15(be1);
      // Inverse Clarke
      al3 <= al2;
      kb3 <= be2 * $signed({1'b0, SQRT3_HALF_Q16});
      pa4 <= 36'(al3) <<< 16;
      pb4 <= -(36'(al3) <<< 15) + 36'(kb3);
      pc4 <= -(36'(al3) <<< 15) - 36'(kb3);
      // Find the phase extremes
      pa5 <= pa4;
      pb5 <= pb4;
      pc5 <= pc4;
      mx5 <= (pa4 >= pb4) ? ((pa4 >= pc4) ? pa4 : pc4) : ((pb4 >= pc4) ? pb4 : pc4);
      mn5 <= (pa4 <= pb4) ? ((pa4 <= pc4) ? pa4 : pc4) : ((pb4 <= pc4) ? pb4 : pc4);
      // Inject the common mode around one half
      ta6 <= 38'sh80000000 + (38'(pa5) <<< 1) - 38'(mx5) - 38'(mn5);
      tb6 <= 38'sh80000000 + (38'(pb5) <<< 1) - 38'(mx5) - 38'(mn5);
      tc6 <= 38'sh80000000 + (38'(pc5) <<< 1) - 38'(mx5) - 38'(mn5);
    end
  end

  // Round, clamp and flag rails into the output register
  always_ff @(posedge clk) begin
    logic [15:0] a, b, c;
    a = to_duty(ta6);
    b = to_duty(tb6);
    c = to_duty(tc6);
    if (adv) begin
      da    <= a;
      db    <= b;
      dc    <= c;
      scale <= tg[6].sc;
      ok    <= tg[6].ok;
      sat   <= tg[6].sat || a == 16'd0 || a == ONE_Q15 || b == 16'd0 || b == ONE_Q15
               || c == 16'd0 || c == ONE_Q15;
    end
  end

endmodule
